[src/scba_pkg.sv]
`timescale 1ns / 1ps

package scba_pkg;

    localparam int SMALL_BLOCKS_DEF  = 256;
    localparam int MEDIUM_BLOCKS_DEF = 64;
    localparam int LARGE_BLOCKS_DEF  = 16;
    localparam int CACHE_DEPTH_DEF   = 16;

    localparam int ACT_W     = 3;
    localparam int DATA_W    = 32;
    localparam int SEL_W     = 5;
    localparam int STATUS_W  = 4;
    localparam int CLS_W     = 2;
    localparam int LOG2_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_STATS = 11;

    localparam logic [ACT_W-1:0] ACT_ALLOC = 3'd0;
    localparam logic [ACT_W-1:0] ACT_FREE  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DRAIN = 3'd2;
    localparam logic [ACT_W-1:0] ACT_READ  = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd4;

    localparam logic [STATUS_W-1:0] ST_CACHE_GRANT = 4'd0;
    localparam logic [STATUS_W-1:0] ST_LIST_GRANT  = 4'd1;
    localparam logic [STATUS_W-1:0] ST_USE_SYSTEM  = 4'd2;
    localparam logic [STATUS_W-1:0] ST_TO_CACHE    = 4'd3;
    localparam logic [STATUS_W-1:0] ST_TO_LIST     = 4'd4;
    localparam logic [STATUS_W-1:0] ST_TO_SYSTEM   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_IGNORED     = 4'd6;
    localparam logic [STATUS_W-1:0] ST_STAT        = 4'd7;
    localparam logic [STATUS_W-1:0] ST_DRAINED     = 4'd8;
    localparam logic [STATUS_W-1:0] ST_LIST_OVF    = 4'd9;

    localparam logic [CLS_W-1:0] CLS_SMALL  = 2'd0;
    localparam logic [CLS_W-1:0] CLS_MEDIUM = 2'd1;
    localparam logic [CLS_W-1:0] CLS_LARGE  = 2'd2;
    localparam logic [CLS_W-1:0] CLS_NONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_BASE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_BASE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_BASE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_LOG2  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MEDIUM_LOG2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_LOG2  = 3'd6;

    localparam logic [DATA_W-1:0] RST_SMALL_BASE  = 32'h0001_0000;
    localparam logic [DATA_W-1:0] RST_MEDIUM_BASE = 32'h0002_0000;
    localparam logic [DATA_W-1:0] RST_LARGE_BASE  = 32'h0004_0000;
    localparam logic [LOG2_W-1:0] RST_SMALL_LOG2  = 5'd6;
    localparam logic [LOG2_W-1:0] RST_MEDIUM_LOG2 = 5'd8;
    localparam logic [LOG2_W-1:0] RST_LARGE_LOG2  = 5'd10;

    localparam logic [SEL_W-1:0] SEL_LIST0  = 5'd11;
    localparam logic [SEL_W-1:0] SEL_CACHE0 = 5'd14;
    localparam logic [SEL_W-1:0] SEL_END    = 5'd17;

    localparam int STAT_HIT0           = 3;
    localparam int STAT_FALLBACK_ALLOC = 6;
    localparam int STAT_FREE0          = 7;
    localparam int STAT_FALLBACK_FREE  = 10;

    typedef struct packed {
        logic             load_in;
        logic             decode;
        logic             exec;
        logic             drain_rd;
        logic             drain_wr;
        logic             drain_done;
        logic [CLS_W-1:0] drain_cls;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic drain_go;
        logic drain_empty;
    } t_sts;

endpackage

[src/scba_ifs.sv]
`timescale 1ns / 1ps

interface scba_req_if;
    logic                          valid;
    logic                          ready;
    logic [scba_pkg::ACT_W-1:0]    action;
    logic [scba_pkg::DATA_W-1:0]   request_bytes;
    logic [scba_pkg::DATA_W-1:0]   address;
    logic [scba_pkg::SEL_W-1:0]    stat_select;
    modport source (output valid, action, request_bytes, address, stat_select, input ready);
    modport sink (input valid, action, request_bytes, address, stat_select, output ready);
endinterface

interface scba_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [scba_pkg::STATUS_W-1:0]  status;
    logic [scba_pkg::DATA_W-1:0]    block_address;
    logic [scba_pkg::CLS_W-1:0]     size_class;
    logic [scba_pkg::DATA_W-1:0]    stat_value;
    modport source (output valid, status, block_address, size_class, stat_value, input ready);
    modport sink (input valid, status, block_address, size_class, stat_value, output ready);
endinterface

interface scba_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [scba_pkg::CFG_IDX_W-1:0] index;
    logic [scba_pkg::DATA_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[src/scba_ctrl.sv]
`timescale 1ns / 1ps

module scba_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  scba_pkg::t_sts   i_sts,
    output scba_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_DRAIN_RD,
        S_DRAIN_WR
    } t_state;

    t_state                          r_state;
    logic [scba_pkg::CLS_W-1:0]      r_dcls;
    logic                            exec_fin;
    logic                            drain_fin;
    logic                            accept;

    always_comb begin
        exec_fin  = (r_state == S_EXEC) && i_sts.out_free && !i_sts.drain_go;
        drain_fin = (r_state == S_DRAIN_RD) && i_sts.drain_empty &&
                    (r_dcls == scba_pkg::CLS_LARGE) && i_sts.out_free;
        o_req_ready = (r_state == S_IDLE) || exec_fin || drain_fin;
        accept      = o_req_ready && i_req_valid;

        o_cmd.load_in    = accept;
        o_cmd.decode     = (r_state == S_DECODE);
        o_cmd.exec       = exec_fin;
        o_cmd.drain_rd   = (r_state == S_DRAIN_RD) && !i_sts.drain_empty;
        o_cmd.drain_wr   = (r_state == S_DRAIN_WR);
        o_cmd.drain_done = drain_fin;
        o_cmd.drain_cls  = r_dcls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dcls  <= scba_pkg::CLS_SMALL;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) r_state <= S_DECODE;
                end
                S_DECODE: begin
                    r_dcls  <= scba_pkg::CLS_SMALL;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (i_sts.drain_go) r_state <= S_DRAIN_RD;
                    else if (exec_fin) r_state <= accept ? S_DECODE : S_IDLE;
                end
                S_DRAIN_RD: begin
                    if (!i_sts.drain_empty) r_state <= S_DRAIN_WR;
                    else if (r_dcls != scba_pkg::CLS_LARGE) r_dcls <= r_dcls + 2'd1;
                    else if (i_sts.out_free) r_state <= accept ? S_DECODE : S_IDLE;
                end
                S_DRAIN_WR: begin
                    r_state <= S_DRAIN_RD;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[src/scba_dp.sv]
`timescale 1ns / 1ps

module scba_dp #(
    parameter int SMALL_BLOCKS  = scba_pkg::SMALL_BLOCKS_DEF,
    parameter int MEDIUM_BLOCKS = scba_pkg::MEDIUM_BLOCKS_DEF,
    parameter int LARGE_BLOCKS  = scba_pkg::LARGE_BLOCKS_DEF,
    parameter int CACHE_DEPTH   = scba_pkg::CACHE_DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  scba_pkg::t_cmd                    i_cmd,
    output scba_pkg::t_sts                    o_sts,
    input  logic [scba_pkg::ACT_W-1:0]        i_action,
    input  logic [scba_pkg::DATA_W-1:0]       i_request_bytes,
    input  logic [scba_pkg::DATA_W-1:0]       i_address,
    input  logic [scba_pkg::SEL_W-1:0]        i_stat_select,
    input  logic                              i_cfg_we,
    input  logic [scba_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [scba_pkg::DATA_W-1:0]       i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [scba_pkg::STATUS_W-1:0]     o_status,
    output logic [scba_pkg::DATA_W-1:0]       o_block_address,
    output logic [scba_pkg::CLS_W-1:0]        o_size_class,
    output logic [scba_pkg::DATA_W-1:0]       o_stat_value
);

    localparam int MAXB = (SMALL_BLOCKS > MEDIUM_BLOCKS) ?
                          ((SMALL_BLOCKS > LARGE_BLOCKS) ? SMALL_BLOCKS : LARGE_BLOCKS) :
                          ((MEDIUM_BLOCKS > LARGE_BLOCKS) ? MEDIUM_BLOCKS : LARGE_BLOCKS);
    localparam int LCW = $clog2(MAXB + 1);
    localparam int IW  = (MAXB > 1) ? $clog2(MAXB) : 1;
    localparam int RW  = scba_pkg::DATA_W + LCW;
    localparam int CCW = $clog2(CACHE_DEPTH + 1);
    localparam int CAW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int DW  = scba_pkg::DATA_W;

    logic                               r_en;
    logic [DW-1:0]                      r_base [3];
    logic [scba_pkg::LOG2_W-1:0]        r_log2 [3];
    logic                               rebuild;

    logic [scba_pkg::ACT_W-1:0]         r_in_action;
    logic [DW-1:0]                      r_in_bytes;
    logic [DW-1:0]                      r_in_addr;
    logic [scba_pkg::SEL_W-1:0]         r_in_sel;

    logic [scba_pkg::CLS_W-1:0]         r_cls;
    logic [scba_pkg::CLS_W-1:0]         r_owner;
    logic [IW-1:0]                      r_fidx;
    logic                               r_dovf;

    logic [DW-1:0]                      r_stat [scba_pkg::NUM_STATS];
    logic [scba_pkg::NUM_STATS-1:0]     bump;
    logic                               stat_clr;

    logic [LCW-1:0]                     lst_cnt [3];
    logic [IW-1:0]                      pop_idx [3];
    logic [2:0]                         lst_full;
    logic [2:0]                         lst_pop;
    logic [2:0]                         lst_push;
    logic [IW-1:0]                      push_idx;
    logic [CCW-1:0]                     cch_cnt [3];
    logic [DW-1:0]                      cch_rd [3];
    logic [2:0]                         cch_full;
    logic [2:0]                         cch_pop;
    logic [2:0]                         cch_push;

    logic [DW-1:0]                      chk_addr;
    logic [2:0]                         hit;
    logic [IW-1:0]                      region_idx [3];
    logic [2:0]                         fits;
    logic [scba_pkg::CLS_W-1:0]         dec_cls;
    logic [scba_pkg::CLS_W-1:0]         dec_owner;

    logic [scba_pkg::STATUS_W-1:0]      ex_status;
    logic [DW-1:0]                      ex_baddr;
    logic [scba_pkg::CLS_W-1:0]         ex_cls;
    logic [DW-1:0]                      ex_sval;
    logic                               drain_ovf;
    logic [scba_pkg::SEL_W-1:0]         sel_off;

    assign rebuild = i_cfg_we && (i_cfg_index == scba_pkg::CFG_ENABLE) &&
                     i_cfg_data[0] && !r_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en      <= 1'b0;
            r_base[0] <= scba_pkg::RST_SMALL_BASE;
            r_base[1] <= scba_pkg::RST_MEDIUM_BASE;
            r_base[2] <= scba_pkg::RST_LARGE_BASE;
            r_log2[0] <= scba_pkg::RST_SMALL_LOG2;
            r_log2[1] <= scba_pkg::RST_MEDIUM_LOG2;
            r_log2[2] <= scba_pkg::RST_LARGE_LOG2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                scba_pkg::CFG_ENABLE:      r_en      <= i_cfg_data[0];
                scba_pkg::CFG_SMALL_BASE:  r_base[0] <= i_cfg_data;
                scba_pkg::CFG_MEDIUM_BASE: r_base[1] <= i_cfg_data;
                scba_pkg::CFG_LARGE_BASE:  r_base[2] <= i_cfg_data;
                scba_pkg::CFG_SMALL_LOG2:  r_log2[0] <= i_cfg_data[scba_pkg::LOG2_W-1:0];
                scba_pkg::CFG_MEDIUM_LOG2: r_log2[1] <= i_cfg_data[scba_pkg::LOG2_W-1:0];
                scba_pkg::CFG_LARGE_LOG2:  r_log2[2] <= i_cfg_data[scba_pkg::LOG2_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in_action <= i_action;
            r_in_bytes  <= i_request_bytes;
            r_in_addr   <= i_address;
            r_in_sel    <= i_stat_select;
        end
        if (i_cmd.decode) begin
            r_cls   <= dec_cls;
            r_owner <= dec_owner;
            r_fidx  <= region_idx[dec_owner[1:0] == 2'd3 ? 2'd0 : dec_owner];
        end
    end

    assign chk_addr = i_cmd.drain_wr ? cch_rd[i_cmd.drain_cls] : r_in_addr;

    for (genvar g = 0; g < 3; g++) begin : g_cls
        localparam int BLK = (g == 0) ? SMALL_BLOCKS :
                             ((g == 1) ? MEDIUM_BLOCKS : LARGE_BLOCKS);
        localparam int AW = (BLK > 1) ? $clog2(BLK) : 1;
        localparam int CW = $clog2(BLK + 1);

        logic [AW-1:0] r_mem [BLK];
        logic [AW-1:0] r_rd;
        logic [AW-1:0] r_rd_p;
        logic          r_rd_fresh;
        logic [CW-1:0] r_cnt;
        logic [CW-1:0] r_mark;
        logic [CW-1:0] cm1;
        logic [DW-1:0] r_cmem [CACHE_DEPTH];
        logic [DW-1:0] r_crd;
        logic [CCW-1:0] r_ccnt;
        logic [CCW-1:0] ccm1;
        logic [RW-1:0] hi;
        logic [DW-1:0] diff;
        logic [DW-1:0] shifted;
        logic [DW:0]   lim;

        assign cm1  = r_cnt - CW'(1);
        assign ccm1 = r_ccnt - CCW'(1);

        // Entries below the low-water mark were never pushed since the rebuild.
        always_ff @(posedge i_clk) begin
            r_rd       <= r_mem[cm1[AW-1:0]];
            r_rd_p     <= cm1[AW-1:0];
            r_rd_fresh <= (cm1 < r_mark);
            if (lst_push[g]) r_mem[r_cnt[AW-1:0]] <= push_idx[AW-1:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || rebuild) begin
                r_cnt  <= CW'(BLK);
                r_mark <= CW'(BLK);
            end else if (lst_pop[g]) begin
                r_cnt <= cm1;
                if (cm1 < r_mark) r_mark <= cm1;
            end else if (lst_push[g]) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end

        always_ff @(posedge i_clk) begin
            r_crd <= r_cmem[ccm1[CAW-1:0]];
            if (cch_push[g]) r_cmem[r_ccnt[CAW-1:0]] <= r_in_addr;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || rebuild) r_ccnt <= '0;
            else if (cch_pop[g]) r_ccnt <= ccm1;
            else if (cch_push[g]) r_ccnt <= r_ccnt + CCW'(1);
        end

        assign lst_cnt[g]  = LCW'(r_cnt);
        assign lst_full[g] = (r_cnt == CW'(BLK));
        assign pop_idx[g]  = IW'(r_rd_fresh ? (AW'(BLK - 1) - r_rd_p) : r_rd);
        assign cch_cnt[g]  = r_ccnt;
        assign cch_rd[g]   = r_crd;
        assign cch_full[g] = (r_ccnt == CCW'(CACHE_DEPTH));

        assign hi      = RW'(r_base[g]) + (RW'(BLK) << r_log2[g]);
        assign hit[g]  = (chk_addr >= r_base[g]) && (RW'(chk_addr) < hi);
        assign diff    = chk_addr - r_base[g];
        assign shifted = diff >> r_log2[g];
        assign region_idx[g] = shifted[IW-1:0];

        assign lim     = (DW + 1)'(1) << r_log2[g];
        assign fits[g] = ({1'b0, r_in_bytes} <= lim);
    end

    always_comb begin
        priority if (fits[0]) dec_cls = scba_pkg::CLS_SMALL;
        else if (fits[1])     dec_cls = scba_pkg::CLS_MEDIUM;
        else if (fits[2])     dec_cls = scba_pkg::CLS_LARGE;
        else                  dec_cls = scba_pkg::CLS_NONE;
        priority if (hit[0]) dec_owner = scba_pkg::CLS_SMALL;
        else if (hit[1])     dec_owner = scba_pkg::CLS_MEDIUM;
        else if (hit[2])     dec_owner = scba_pkg::CLS_LARGE;
        else                 dec_owner = scba_pkg::CLS_NONE;
    end

    always_comb begin
        ex_status = scba_pkg::ST_IGNORED;
        ex_baddr  = '0;
        ex_cls    = scba_pkg::CLS_SMALL;
        ex_sval   = '0;
        lst_pop   = '0;
        lst_push  = '0;
        cch_pop   = '0;
        cch_push  = '0;
        push_idx  = r_fidx;
        bump      = '0;
        stat_clr  = 1'b0;
        drain_ovf = 1'b0;
        sel_off   = '0;
        if (i_cmd.exec) begin
            unique case (r_in_action)
                scba_pkg::ACT_ALLOC: begin
                    ex_cls    = r_cls;
                    ex_status = scba_pkg::ST_USE_SYSTEM;
                    if (r_en) begin
                        if (r_cls == scba_pkg::CLS_NONE) begin
                            bump[scba_pkg::STAT_FALLBACK_ALLOC] = 1'b1;
                        end else if (cch_cnt[r_cls] != '0) begin
                            cch_pop[r_cls] = 1'b1;
                            ex_baddr       = cch_rd[r_cls];
                            bump[r_cls]    = 1'b1;
                            bump[scba_pkg::STAT_HIT0 + int'(r_cls)] = 1'b1;
                            ex_status      = scba_pkg::ST_CACHE_GRANT;
                        end else if (lst_cnt[r_cls] != '0) begin
                            lst_pop[r_cls] = 1'b1;
                            ex_baddr = r_base[r_cls] + (DW'(pop_idx[r_cls]) << r_log2[r_cls]);
                            bump[r_cls]    = 1'b1;
                            bump[scba_pkg::STAT_HIT0 + int'(r_cls)] = 1'b1;
                            ex_status      = scba_pkg::ST_LIST_GRANT;
                        end else begin
                            bump[scba_pkg::STAT_FALLBACK_ALLOC] = 1'b1;
                        end
                    end
                end
                scba_pkg::ACT_FREE: begin
                    ex_cls = r_cls;
                    if (r_in_addr == '0) begin
                        ex_status = scba_pkg::ST_IGNORED;
                    end else if (!r_en) begin
                        ex_status = scba_pkg::ST_TO_SYSTEM;
                    end else if (r_owner == scba_pkg::CLS_NONE) begin
                        bump[scba_pkg::STAT_FALLBACK_FREE] = 1'b1;
                        ex_status = scba_pkg::ST_TO_SYSTEM;
                    end else if (r_cls != scba_pkg::CLS_NONE && !cch_full[r_cls]) begin
                        cch_push[r_cls] = 1'b1;
                        bump[scba_pkg::STAT_FREE0 + int'(r_cls)] = 1'b1;
                        ex_status = scba_pkg::ST_TO_CACHE;
                    end else if (!lst_full[r_owner]) begin
                        lst_push[r_owner] = 1'b1;
                        bump[scba_pkg::STAT_FREE0 + int'(r_owner)] = 1'b1;
                        ex_status = scba_pkg::ST_TO_LIST;
                    end else begin
                        ex_status = scba_pkg::ST_LIST_OVF;
                    end
                end
                scba_pkg::ACT_READ: begin
                    ex_status = scba_pkg::ST_STAT;
                    if (r_in_sel < scba_pkg::SEL_LIST0) begin
                        ex_sval = r_stat[r_in_sel[3:0]];
                    end else if (r_in_sel < scba_pkg::SEL_CACHE0) begin
                        sel_off = r_in_sel - scba_pkg::SEL_LIST0;
                        ex_sval = DW'(lst_cnt[sel_off[1:0]]);
                    end else if (r_in_sel < scba_pkg::SEL_END) begin
                        sel_off = r_in_sel - scba_pkg::SEL_CACHE0;
                        ex_sval = DW'(cch_cnt[sel_off[1:0]]);
                    end
                end
                scba_pkg::ACT_CLEAR: begin
                    stat_clr  = 1'b1;
                    ex_status = scba_pkg::ST_STAT;
                end
                default: begin
                    ex_status = scba_pkg::ST_IGNORED;
                end
            endcase
        end
        if (i_cmd.drain_rd) cch_pop[i_cmd.drain_cls] = 1'b1;
        if (i_cmd.drain_wr && hit[i_cmd.drain_cls]) begin
            if (!lst_full[i_cmd.drain_cls]) begin
                lst_push[i_cmd.drain_cls] = 1'b1;
                push_idx = region_idx[i_cmd.drain_cls];
            end else begin
                drain_ovf = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || rebuild || stat_clr) begin
            for (int i = 0; i < scba_pkg::NUM_STATS; i++) r_stat[i] <= '0;
        end else begin
            for (int i = 0; i < scba_pkg::NUM_STATS; i++) begin
                if (bump[i]) r_stat[i] <= r_stat[i] + DW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.decode) r_dovf <= 1'b0;
        else if (drain_ovf) r_dovf <= 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.exec || i_cmd.drain_done) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
        if (i_cmd.exec) begin
            o_status        <= ex_status;
            o_block_address <= ex_baddr;
            o_size_class    <= ex_cls;
            o_stat_value    <= ex_sval;
        end else if (i_cmd.drain_done) begin
            o_status        <= r_dovf ? scba_pkg::ST_LIST_OVF : scba_pkg::ST_DRAINED;
            o_block_address <= '0;
            o_size_class    <= scba_pkg::CLS_SMALL;
            o_stat_value    <= '0;
        end
    end

    assign o_sts.out_free    = !o_out_valid || i_out_ready;
    assign o_sts.drain_go    = (r_in_action == scba_pkg::ACT_DRAIN) && r_en;
    assign o_sts.drain_empty = (cch_cnt[i_cmd.drain_cls] == '0);

endmodule

[src/size_class_block_allocator_core.sv]
`timescale 1ns / 1ps

// Channel   Role   Handshake      Payload
// i_req     sink   valid/ready    action, request_bytes, address, stat_select
// o_rsp     source valid/ready    status, block_address, size_class, stat_value
// i_cfg     sink   valid/ready    index, data (ready is always high)
//
// Alloc, free, read and clear each pass through decode, with the list and cache
// reads, then execute; the single-port read-modify-write of the stacks sets this.
// Drain walks the three caches in turn, a read state then a write state per cached entry.
// Reset and a rising enable write rebuild the lists at once, with no clearing pass.
// A result waiting in the output register holds the next transaction in execute,
// and no further transaction is accepted until that result is taken.

module size_class_block_allocator_core #(
    parameter int SMALL_BLOCKS  = scba_pkg::SMALL_BLOCKS_DEF,
    parameter int MEDIUM_BLOCKS = scba_pkg::MEDIUM_BLOCKS_DEF,
    parameter int LARGE_BLOCKS  = scba_pkg::LARGE_BLOCKS_DEF,
    parameter int CACHE_DEPTH   = scba_pkg::CACHE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scba_req_if.sink    i_req,
    scba_rsp_if.source  o_rsp,
    scba_cfg_if.sink    i_cfg
);

    scba_pkg::t_cmd cmd;
    scba_pkg::t_sts sts;

    assign i_cfg.ready = 1'b1;

    scba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    scba_dp #(
        .SMALL_BLOCKS  (SMALL_BLOCKS),
        .MEDIUM_BLOCKS (MEDIUM_BLOCKS),
        .LARGE_BLOCKS  (LARGE_BLOCKS),
        .CACHE_DEPTH   (CACHE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_action        (i_req.action),
        .i_request_bytes (i_req.request_bytes),
        .i_address       (i_req.address),
        .i_stat_select   (i_req.stat_select),
        .i_cfg_we        (i_cfg.valid),
        .i_cfg_index     (i_cfg.index),
        .i_cfg_data      (i_cfg.data),
        .o_out_valid     (o_rsp.valid),
        .i_out_ready     (o_rsp.ready),
        .o_status        (o_rsp.status),
        .o_block_address (o_rsp.block_address),
        .o_size_class    (o_rsp.size_class),
        .o_stat_value    (o_rsp.stat_value)
    );

endmodule
